FILE: rtl/tce_pkg.sv
// Shared types and constants for the text console engine.
package tce_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_STEPS_DEF = 4;

  localparam int KIND_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 12;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int OCOL_W  = 7;
  localparam int OROW_W  = 5;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CR,
    OP_NL_DOWN,
    OP_SCR_START,
    OP_SCR_STEP,
    OP_BLK_STEP,
    OP_CLR_START,
    OP_TAB_INC,
    OP_PUT,
    OP_DEL_STEP,
    OP_RD_ISSUE,
    OP_RESULT
  } tce_op_t;

  typedef struct packed {
    tce_op_t op;
    logic    init_blank;
  } tce_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_nl;
    logic              is_cr;
    logic              is_tab;
    logic              col_wrap;
    logic              row_last;
    logic              at_origin;
    logic              cnt_zero;
    logic              tab_done;
    logic              scr_last;
    logic              swp_last;
    logic              out_free;
  } tce_sts_t;

endpackage

FILE: rtl/tce_ram.sv
// Generic simple dual-port RAM with registered read.
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tce_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module tce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tce_pkg::tce_sts_t sts,
  output tce_pkg::tce_cmd_t cmd
);

  import tce_pkg::*;

  typedef enum logic [3:0] {
    S_BLK,
    S_IDLE,
    S_DISP,
    S_NL,
    S_SCR,
    S_SCRD,
    S_TAB,
    S_PUT,
    S_DEL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   init_r, init_nxt;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    init_nxt       = init_r;
    cmd.op         = OP_NONE;
    cmd.init_blank = init_r;
    in_ready       = 1'b0;
    case (state_r)
      S_BLK: begin
        cmd.op = OP_BLK_STEP;
        if (sts.swp_last) begin
          state_nxt = ret_r;
          init_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.kind)
          KIND_CHAR: begin
            if (sts.is_nl) begin
              ret_nxt   = S_DONE;
              state_nxt = S_NL;
            end else if (sts.is_cr) begin
              cmd.op    = OP_CR;
              state_nxt = S_DONE;
            end else if (sts.is_tab) begin
              state_nxt = S_TAB;
            end else begin
              state_nxt = S_PUT;
            end
          end
          KIND_DELETE: state_nxt = S_DEL;
          KIND_CLEAR: begin
            cmd.op    = OP_CLR_START;
            ret_nxt   = S_DONE;
            state_nxt = S_BLK;
          end
          default: begin
            cmd.op    = OP_RD_ISSUE;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_NL: begin
        if (sts.row_last) begin
          cmd.op    = OP_SCR_START;
          state_nxt = S_SCR;
        end else begin
          cmd.op    = OP_NL_DOWN;
          state_nxt = ret_r;
        end
      end
      S_SCR: begin
        cmd.op = OP_SCR_STEP;
        if (sts.scr_last) begin
          state_nxt = S_SCRD;
        end
      end
      S_SCRD: state_nxt = S_BLK;
      S_TAB: begin
        if (sts.tab_done) begin
          state_nxt = S_DONE;
        end else if (sts.col_wrap) begin
          ret_nxt   = S_TAB;
          state_nxt = S_NL;
        end else begin
          cmd.op = OP_TAB_INC;
        end
      end
      S_PUT: begin
        if (sts.col_wrap) begin
          ret_nxt   = S_PUT;
          state_nxt = S_NL;
        end else begin
          cmd.op    = OP_PUT;
          state_nxt = S_DONE;
        end
      end
      S_DEL: begin
        if (sts.cnt_zero || sts.at_origin) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_DEL_STEP;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BLK;
      ret_r   <= S_IDLE;
      init_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      init_r  <= init_nxt;
    end
  end

endmodule

FILE: rtl/tce_datapath.sv
// Datapath: cursor, attribute, sweep address, screen store and result register.
module tce_datapath #(
  parameter int COLUMNS   = tce_pkg::COLUMNS_DEF,
  parameter int ROWS      = tce_pkg::ROWS_DEF,
  parameter int TAB_STEPS = tce_pkg::TAB_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tce_pkg::tce_cmd_t            cmd,
  output tce_pkg::tce_sts_t            sts,
  input  logic [tce_pkg::KIND_W-1:0]   in_kind,
  input  logic [tce_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tce_pkg::COUNT_W-1:0]  in_delete_count,
  input  logic [tce_pkg::RROW_W-1:0]   in_read_row,
  input  logic [tce_pkg::RCOL_W-1:0]   in_read_column,
  input  logic                         cfg_write,
  input  logic [tce_pkg::ATTR_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tce_pkg::OCOL_W-1:0]   out_cursor_column,
  output logic [tce_pkg::OROW_W-1:0]   out_cursor_row,
  output logic [tce_pkg::CELL_W-1:0]   out_cell_data
);

  import tce_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int TC_W       = $clog2(TAB_STEPS + 1);

  logic [ATTR_W-1:0]  attr_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  swp_r, swp_nxt;
  logic [TC_W-1:0]    tcnt_r, tcnt_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               cp_pend_r;
  logic [ADDR_W-1:0]  cp_addr_r;
  logic               out_valid_r;
  logic [OCOL_W-1:0]  out_col_r;
  logic [OROW_W-1:0]  out_row_r;
  logic [CELL_W-1:0]  out_data_r;
  logic [KIND_W-1:0]  kind_r;
  logic [CHAR_W-1:0]  code_r;
  logic [RROW_W-1:0]  rrow_r;
  logic [RCOL_W-1:0]  rcol_r;
  logic               rd_ok_r;

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [CELL_W-1:0]  wdata, rdata, blank;
  logic [ADDR_W-1:0]  cur_addr, del_addr, rd_addr;
  logic [COL_W-1:0]   del_col;
  logic [ROW_W-1:0]   del_row;
  logic               rd_ok;

  tce_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign blank    = {(cmd.init_blank ? RESET_ATTR : attr_r), BLANK_CHAR};
  assign cur_addr = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign del_col  = (col_r == '0) ? COL_W'(COLUMNS - 1) : col_r - 1'b1;
  assign del_row  = (col_r == '0) ? row_r - 1'b1 : row_r;
  assign del_addr = ADDR_W'(del_row) * ADDR_W'(COLUMNS) + ADDR_W'(del_col);
  assign rd_addr  = ADDR_W'(rrow_r) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_r);
  assign rd_ok    = (int'(rrow_r) < ROWS) && (int'(rcol_r) < COLUMNS);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    swp_nxt  = swp_r;
    tcnt_nxt = tcnt_r;
    cnt_nxt  = cnt_r;
    we       = cp_pend_r;
    waddr    = cp_addr_r;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = swp_r + ADDR_W'(COLUMNS);
    case (cmd.op)
      OP_LOAD: begin
        tcnt_nxt = '0;
        cnt_nxt  = in_delete_count;
      end
      OP_CR: col_nxt = '0;
      OP_NL_DOWN: begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end
      OP_SCR_START: begin
        col_nxt = '0;
        swp_nxt = '0;
      end
      OP_SCR_STEP: begin
        re      = 1'b1;
        swp_nxt = swp_r + 1'b1;
      end
      OP_BLK_STEP: begin
        we      = 1'b1;
        waddr   = swp_r;
        wdata   = blank;
        swp_nxt = swp_r + 1'b1;
      end
      OP_CLR_START: begin
        col_nxt = '0;
        row_nxt = '0;
        swp_nxt = '0;
      end
      OP_TAB_INC: begin
        col_nxt  = col_r + 1'b1;
        tcnt_nxt = tcnt_r + 1'b1;
      end
      OP_PUT: begin
        we      = 1'b1;
        waddr   = cur_addr;
        wdata   = {attr_r, code_r};
        col_nxt = col_r + 1'b1;
      end
      OP_DEL_STEP: begin
        we      = 1'b1;
        waddr   = del_addr;
        wdata   = blank;
        col_nxt = del_col;
        row_nxt = del_row;
        cnt_nxt = cnt_r - 1'b1;
      end
      OP_RD_ISSUE: begin
        re    = rd_ok;
        raddr = rd_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      swp_r       <= '0;
      tcnt_r      <= '0;
      cnt_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr_r <= cfg_data;
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      swp_r     <= swp_nxt;
      tcnt_r    <= tcnt_nxt;
      cnt_r     <= cnt_nxt;
      cp_pend_r <= (cmd.op == OP_SCR_STEP);
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= swp_r;
    if (cmd.op == OP_LOAD) begin
      kind_r <= in_kind;
      code_r <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
    if (cmd.op == OP_RD_ISSUE) begin
      rd_ok_r <= rd_ok;
    end
    if (cmd.op == OP_RESULT) begin
      out_col_r  <= OCOL_W'(col_r);
      out_row_r  <= OROW_W'(row_r);
      out_data_r <= (kind_r == KIND_READ && rd_ok_r) ? rdata : '0;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.is_nl     = (code_r == CH_NEWLINE);
  assign sts.is_cr     = (code_r == CH_RETURN);
  assign sts.is_tab    = (code_r == CH_TAB);
  assign sts.col_wrap  = (col_r == COL_W'(COLUMNS));
  assign sts.row_last  = (row_r == ROW_W'(ROWS - 1));
  assign sts.at_origin = (col_r == '0) && (row_r == '0);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.tab_done  = (tcnt_r == TC_W'(TAB_STEPS));
  assign sts.scr_last  = (swp_r == ADDR_W'(CELL_COUNT - COLUMNS - 1));
  assign sts.swp_last  = (swp_r == ADDR_W'(CELL_COUNT - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cell_data     = out_data_r;

endmodule

FILE: rtl/text_console_engine_core.sv
// Top level of the text console engine: controller, datapath and screen store.
//
// Usage: requests enter on the in_ channel (kind, char_code, delete_count,
// read_row, read_column) under valid/ready; each request yields one result on
// the out_ channel with the cursor after the request and, for a read, the cell.
// The cfg_ channel writes the text attribute; cfg_ready is always high. The user
// must write it only while no request is in flight; not enforced in the block.
// One request is worked at a time; in_ready is high once the previous result
// sits in the output register, so the next request is taken while it waits.
// The store holds ROWS*COLUMNS cells; a clear blanks all of them, and each
// newline on the last row (also from a wrap) adds a scroll of the store,
// one store write per cycle.
// At reset the cursor goes home, the attribute returns to 0x0F and a clearing
// pass blanks all ROWS*COLUMNS cells of the store before in_ready rises.
// A stalled receiver holds the result in the output register; after it the
// block waits in its final state until the register frees.
module text_console_engine_core #(
  parameter int COLUMNS   = tce_pkg::COLUMNS_DEF,
  parameter int ROWS      = tce_pkg::ROWS_DEF,
  parameter int TAB_STEPS = tce_pkg::TAB_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tce_pkg::KIND_W-1:0]  in_kind,
  input  logic [tce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tce_pkg::COUNT_W-1:0] in_delete_count,
  input  logic [tce_pkg::RROW_W-1:0]  in_read_row,
  input  logic [tce_pkg::RCOL_W-1:0]  in_read_column,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tce_pkg::OCOL_W-1:0]  out_cursor_column,
  output logic [tce_pkg::OROW_W-1:0]  out_cursor_row,
  output logic [tce_pkg::CELL_W-1:0]  out_cell_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tce_pkg::ATTR_W-1:0]  cfg_data
);

  import tce_pkg::*;

  tce_cmd_t cmd;
  tce_sts_t sts;

  assign cfg_ready = 1'b1;

  tce_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tce_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEPS(TAB_STEPS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_char_code     (in_char_code),
    .in_delete_count  (in_delete_count),
    .in_read_row      (in_read_row),
    .in_read_column   (in_read_column),
    .cfg_write        (cfg_valid & cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row   (out_cursor_row),
    .out_cell_data    (out_cell_data)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for text_console_engine_core: cursor, screen store and cell reads.
`timescale 1ns / 1ps

module testbench;
  import tce_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int CYCLE_LIMIT     = 8_000_000;
  localparam int CELLS           = ROWS_DEF * COLUMNS_DEF;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [COUNT_W-1:0] delete_count;
    logic [RROW_W-1:0]  read_row;
    logic [RCOL_W-1:0]  read_column;
  } console_request_t;

  typedef struct packed {
    logic [OCOL_W-1:0] column;
    logic [OROW_W-1:0] row;
    logic [CELL_W-1:0] data;
  } console_result_t;

  // Mirror of the screen, cursor and attribute; queues the cursor/cell each request yields.
  class console_board;
    bit [CELL_W-1:0] cells [CELLS];
    int col;
    int row;
    bit [ATTR_W-1:0] attribute;
    console_result_t due[$];
    int errors;

    function new();
      attribute = RESET_ATTR;
      clear_screen();
    endfunction

    function int pending();
      return due.size();
    endfunction

    function bit [CELL_W-1:0] blank();
      return {attribute, BLANK_CHAR};
    endfunction

    function void clear_screen();
      col = 0;
      row = 0;
      foreach (cells[i]) cells[i] = blank();
    endfunction

    function void line_feed();
      int i;
      if (row < ROWS_DEF - 1) begin
        row++;
      end else begin
        for (i = 0; i < CELLS - COLUMNS_DEF; i++) cells[i] = cells[i + COLUMNS_DEF];
        for (i = CELLS - COLUMNS_DEF; i < CELLS; i++) cells[i] = blank();
      end
      col = 0;
    endfunction

    function void note_request(console_request_t r);
      console_result_t e;
      int i;
      e.data = '0;
      case (r.kind)
        KIND_CHAR: begin
          if (r.char_code == CH_NEWLINE) begin
            line_feed();
          end else if (r.char_code == CH_RETURN) begin
            col = 0;
          end else if (r.char_code == CH_TAB) begin
            for (i = 0; i < TAB_STEPS_DEF; i++) begin
              if (col >= COLUMNS_DEF) line_feed();
              col++;
            end
          end else begin
            if (col >= COLUMNS_DEF) line_feed();
            cells[row * COLUMNS_DEF + col] = {attribute, r.char_code};
            col++;
          end
        end
        KIND_DELETE: begin
          for (i = 0; i < int'(r.delete_count); i++) begin
            if (col == 0) begin
              if (row == 0) break;
              row--;
              col = COLUMNS_DEF - 1;
            end else begin
              col--;
            end
            cells[row * COLUMNS_DEF + col] = blank();
          end
        end
        KIND_CLEAR: clear_screen();
        KIND_READ: begin
          if (r.read_row < ROWS_DEF && r.read_column < COLUMNS_DEF)
            e.data = cells[int'(r.read_row) * COLUMNS_DEF + int'(r.read_column)];
        end
      endcase
      e.column = OCOL_W'(col);
      e.row    = OROW_W'(row);
      due.push_back(e);
    endfunction

    function void mismatch(string what, int exp_v, int act_v);
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(console_result_t got);
      console_result_t e;
      if (due.size() == 0) begin
        mismatch("unrequested result", 0, int'(got));
        return;
      end
      e = due.pop_front();
      if (got.column !== e.column)
        mismatch("cursor_column", int'(e.column), int'(got.column));
      if (got.row !== e.row)
        mismatch("cursor_row", int'(e.row), int'(got.row));
      if (got.data !== e.data)
        mismatch("cell_data", int'(e.data), int'(got.data));
    endfunction
  endclass

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind         = '0;
  logic [CHAR_W-1:0]   in_char_code    = '0;
  logic [COUNT_W-1:0]  in_delete_count = '0;
  logic [RROW_W-1:0]   in_read_row     = '0;
  logic [RCOL_W-1:0]   in_read_column  = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [OCOL_W-1:0]   out_cursor_column;
  logic [OROW_W-1:0]   out_cursor_row;
  logic [CELL_W-1:0]   out_cell_data;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [ATTR_W-1:0]   cfg_data        = '0;

  console_board board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int accepted       = 0;
  int cycle_count    = 0;

  text_console_engine_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_char_code      (in_char_code),
    .in_delete_count   (in_delete_count),
    .in_read_row       (in_read_row),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_cell_data     (out_cell_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : receive
    console_result_t seen;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid === 1'b1 && out_ready) begin
      seen = {out_cursor_column, out_cursor_row, out_cell_data};
      board.check_result(seen);
    end
  end

  function automatic console_request_t request_of(int kind, int code, int count,
                                                  int rrow, int rcol);
    console_request_t r;
    r.kind         = KIND_W'(kind);
    r.char_code    = CHAR_W'(code);
    r.delete_count = COUNT_W'(count);
    r.read_row     = RROW_W'(rrow);
    r.read_column  = RCOL_W'(rcol);
    return r;
  endfunction

  task automatic send_request(input console_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= r.kind;
    in_char_code    <= r.char_code;
    in_delete_count <= r.delete_count;
    in_read_row     <= r.read_row;
    in_read_column  <= r.read_column;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    board.note_request(r);
    accepted++;
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    board.attribute = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int quota;
    int pick;
    int k;
    int n;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reads at the corners and out of range, controls, wrap and delete edges
    send_request(request_of(KIND_READ, $urandom, $urandom, 0, 0));
    send_request(request_of(KIND_READ, $urandom, $urandom, ROWS_DEF - 1, COLUMNS_DEF - 1));
    send_request(request_of(KIND_READ, $urandom, $urandom, ROWS_DEF, 0));
    send_request(request_of(KIND_READ, $urandom, $urandom, 0, COLUMNS_DEF));
    send_request(request_of(KIND_READ, $urandom, $urandom, 31, 127));
    send_request(request_of(KIND_CHAR, 8'h41, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, 8'h00, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, 8'hFF, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, CH_TAB, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, CH_RETURN, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, CH_NEWLINE, $urandom, $urandom, $urandom));
    // back across the row boundary to the end of row 0
    send_request(request_of(KIND_DELETE, $urandom, 1, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, 8'h5A, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_READ, $urandom, $urandom, 0, COLUMNS_DEF - 1));
    send_request(request_of(KIND_DELETE, $urandom, 1, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, 8'h5A, $urandom, $urandom, $urandom));
    // tab with a wrap pending
    send_request(request_of(KIND_CHAR, CH_TAB, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_DELETE, $urandom, 0, $urandom, $urandom));
    send_request(request_of(KIND_CHAR, 8'h78, $urandom, $urandom, $urandom));
    // runs into the origin and stops there
    send_request(request_of(KIND_DELETE, $urandom, 4095, $urandom, $urandom));
    send_request(request_of(KIND_READ, $urandom, $urandom, 0, 0));
    send_request(request_of(KIND_CHAR, 8'h41, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
    send_request(request_of(KIND_READ, $urandom, $urandom, 0, 0));

    for (phase = 0; phase < PHASES; phase++) begin
      in_valid <= 1'b0;
      write_attribute(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : ATTR_W'($urandom));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      quota = accepted + ITEMS_PER_PHASE;
      while (accepted < quota) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // a line of text, long ones wrap
          n = ($urandom_range(99) < 20) ? $urandom_range(160) : $urandom_range(40);
          repeat (n)
            send_request(request_of(KIND_CHAR, ($urandom_range(99) < 15) ? $urandom_range(255)
                                    : $urandom_range(126, 32), $urandom, $urandom, $urandom));
          k = $urandom_range(99);
          if (k >= 60 && k < 90)
            send_request(request_of(KIND_CHAR, CH_RETURN, $urandom, $urandom, $urandom));
          if (k < 80)
            send_request(request_of(KIND_CHAR, CH_NEWLINE, $urandom, $urandom, $urandom));
        end else if (pick < 56) begin
          repeat ($urandom_range(1, 6))
            send_request(request_of(KIND_CHAR, CH_NEWLINE, $urandom, $urandom, $urandom));
        end else if (pick < 66) begin
          repeat ($urandom_range(1, 24))
            send_request(request_of(KIND_CHAR, $urandom_range(1) ? CH_TAB : $urandom_range(126, 32),
                                    $urandom, $urandom, $urandom));
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6)) begin
            k = $urandom_range(99);
            if (k < 65)
              send_request(request_of(KIND_READ, $urandom, $urandom,
                                      $urandom_range(ROWS_DEF - 1), $urandom_range(COLUMNS_DEF - 1)));
            else if (k < 85)
              send_request(request_of(KIND_READ, $urandom, $urandom, board.row,
                                      board.col > 0 ? board.col - 1 : 0));
            else
              send_request(request_of(KIND_READ, $urandom, $urandom, $urandom, $urandom));
          end
        end else if (pick < 92) begin
          k = $urandom_range(99);
          n = (k < 70) ? $urandom_range(10) : (k < 95) ? $urandom_range(300) : $urandom_range(4095);
          send_request(request_of(KIND_DELETE, $urandom, n, $urandom, $urandom));
        end else if (pick < 94) begin
          send_request(request_of(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
        end else begin
          // noise: any kind, any field
          repeat ($urandom_range(1, 4)) begin
            k = $urandom_range(3);
            if (k == KIND_DELETE) n = $urandom_range(63);
            else n = $urandom;
            send_request(request_of(k, $urandom, n, $urandom, $urandom));
          end
        end
      end
    end
    in_valid <= 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: text_console_engine_core.f
rtl/tce_pkg.sv
rtl/tce_ram.sv
rtl/tce_ctrl.sv
rtl/tce_datapath.sv
rtl/text_console_engine_core.sv
bench/testbench.sv
